[sv/ife_pkg.sv]
package ife_pkg;

    localparam int C_MAX_FRAME_LENGTH = 512;
    localparam int C_CFG_W            = 10;
    localparam int C_WEIGHT_W         = 16;
    localparam int C_VALUE_W          = 16;
    localparam int C_COEF_W           = 17;
    localparam int C_STORE_W          = 24;
    localparam int C_PROD_W           = 34;
    localparam int C_SUM_W            = 27;
    localparam int C_TDATA_IN_W       = 32;
    localparam int C_TDATA_OUT_W      = 16;

    // Fixed-point one in Q0.16.
    localparam logic [C_WEIGHT_W:0] C_ONE_Q16 = 17'h10000;

    // One element between the frame stage and the multiplier cell.
    typedef struct packed {
        logic                          valid;
        logic signed [C_VALUE_W-1:0]   x;
        logic        [C_COEF_W-1:0]    wa;      // remain weight or current weight
        logic        [C_COEF_W-1:0]    wb;      // overflow weight of a firing frame
        logic                          fires;
        logic                          clears;
        logic                          last;
        logic                          written; // entry written since reset
    } t_item;

    // One element between the multiplier cell and the accumulate cell.
    typedef struct packed {
        logic                          valid;
        logic signed [C_PROD_W-1:0]    pa;
        logic signed [C_PROD_W-1:0]    pb;
        logic                          fires;
        logic                          clears;
        logic                          last;
        logic                          written;
        logic signed [C_STORE_W-1:0]   rd_data;
    } t_prod;

    function automatic logic signed [C_STORE_W-1:0] f_sat24(
        input logic signed [C_SUM_W-1:0] v
    );
        logic signed [C_STORE_W-1:0] r;
        if (v > C_SUM_W'(24'sh7FFFFF)) begin
            r = 24'sh7FFFFF;
        end else if (v < C_SUM_W'(-8388608)) begin
            r = 24'sh800000;
        end else begin
            r = v[C_STORE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [C_VALUE_W-1:0] f_sat16(
        input logic signed [C_SUM_W-1:0] v
    );
        logic signed [C_VALUE_W-1:0] r;
        if (v > C_SUM_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < C_SUM_W'(-32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[C_VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

[sv/integrate_and_fire_embedding_unit.sv]
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       tdata: weight, feature_value; tuser: first_of_sequence
// m_*       out  m_tvalid / m_tready       tdata: embedding_value; tlast: last_of_embedding
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_data: frame_length
//
// One item is accepted per cycle while s_tready is high. An item passes the
// frame register and store read, then the multiply register, then
// accumulate with store write-back into the output register that drives m_tvalid.
// The store read-modify-write of the same entry by close items is resolved by
// forwarding the two newest write values. Reset is synchronous; the store gets
// no clearing pass, since a fill count marks the entries never written. A
// stalled output register holds the whole pipeline and drops s_tready.
module integrate_and_fire_embedding_unit
    import ife_pkg::*;
#(
    parameter int MAX_FRAME_LENGTH = C_MAX_FRAME_LENGTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [C_TDATA_IN_W-1:0]  s_tdata,   // [15:0] weight, [31:16] feature_value
    input  logic                     s_tuser,   // [0] first_of_sequence
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [C_TDATA_OUT_W-1:0] m_tdata,   // [15:0] embedding_value
    output logic                     m_tlast,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [C_CFG_W-1:0]       i_cfg_data
);

    localparam int AW = (MAX_FRAME_LENGTH > 1) ? $clog2(MAX_FRAME_LENGTH) : 1;

    logic                        adv;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic signed [C_STORE_W-1:0] rd_data;
    t_item                       item_b;
    logic [AW-1:0]               addr_b;
    t_prod                       prod_c;
    logic [AW-1:0]               addr_c;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic signed [C_STORE_W-1:0] wr_data;
    logic                        res_valid;
    logic signed [C_VALUE_W-1:0] res_value;
    logic                        res_last;

    logic                        r_out_valid;
    logic [C_TDATA_OUT_W-1:0]    r_out_data;
    logic                        r_out_last;

    // The pipeline moves whenever the output register is empty or being drained.
    assign adv         = !r_out_valid || m_tready;
    assign s_tready    = adv;
    assign o_cfg_ready = 1'b1;

    ife_frame #(
        .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_en       (adv),
        .i_valid    (s_tvalid),
        .i_weight   (s_tdata[15:0]),
        .i_feature  ($signed(s_tdata[31:16])),
        .i_first    (s_tuser),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_item     (item_b),
        .o_addr     (addr_b)
    );

    ife_store #(
        .DEPTH(MAX_FRAME_LENGTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    ife_mult_cell #(
        .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
    ) u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_item   (item_b),
        .i_addr   (addr_b),
        .i_rd_data(rd_data),
        .o_prod   (prod_c),
        .o_addr   (addr_c)
    );

    ife_acc_cell #(
        .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
    ) u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_prod     (prod_c),
        .i_addr     (addr_c),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_res_valid(res_valid),
        .o_res_value(res_value),
        .o_res_last (res_last)
    );

    // Output register: only elements of a firing frame produce an item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out_data <= res_value;
            r_out_last <= res_last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // Input back-pressure comes only from a full, stalled output register.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // A firing element that leaves the accumulate cell shows up on the output.
    a_fire_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && prod_c.valid && prod_c.fires) |=> m_tvalid)
        else $error("firing element did not reach the output register");

    // Every element moving out of the accumulate cell writes its store entry.
    a_write_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && prod_c.valid) |-> wr_en)
        else $error("element left without store write-back");
`endif

endmodule

[sv/ife_store.sv]
module ife_store
    import ife_pkg::*;
#(
    parameter int DEPTH = C_MAX_FRAME_LENGTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic signed [C_STORE_W-1:0] o_rd_data,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic signed [C_STORE_W-1:0] i_wr_data
);

    logic signed [C_STORE_W-1:0] r_mem [DEPTH];
    logic signed [C_STORE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/ife_frame.sv]
module ife_frame
    import ife_pkg::*;
#(
    parameter int MAX_FRAME_LENGTH = C_MAX_FRAME_LENGTH,
    parameter int AW = (MAX_FRAME_LENGTH > 1) ? $clog2(MAX_FRAME_LENGTH) : 1,
    parameter int FW = $clog2(MAX_FRAME_LENGTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [C_CFG_W-1:0]          i_cfg_data,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [C_WEIGHT_W-1:0]       i_weight,
    input  logic signed [C_VALUE_W-1:0] i_feature,
    input  logic                        i_first,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    output t_item                       o_item,
    output logic [AW-1:0]               o_addr
);

    logic [C_CFG_W-1:0]    r_len;
    logic                  r_len_dflt;
    logic [AW-1:0]         r_cnt;
    logic [FW-1:0]         r_fill;
    logic [C_WEIGHT_W-1:0] r_acc;
    logic                  r_fires;
    logic                  r_clears;
    logic [C_COEF_W-1:0]   r_remain;
    logic [C_COEF_W-1:0]   r_cw;
    t_item                 r_item;
    logic [AW-1:0]         r_addr;

    logic                  accept;
    logic                  frame_start;
    logic [FW-1:0]         eff_len;
    logic [FW-1:0]         e_ext;
    logic [FW-1:0]         e_next;
    logic [C_WEIGHT_W-1:0] acc_base;
    logic [C_COEF_W-1:0]   sum;
    logic [C_COEF_W-1:0]   ovf;
    logic [C_WEIGHT_W-1:0] n_acc;
    logic                  n_fires;
    logic                  n_clears;
    logic [C_COEF_W-1:0]   n_remain;
    logic [C_COEF_W-1:0]   n_cw;
    logic [AW-1:0]         n_cnt;

    assign accept      = i_valid && i_en;
    assign frame_start = (r_cnt == '0);
    assign e_ext       = FW'(r_cnt);
    assign e_next      = e_ext + FW'(1);

    // A length of zero acts as one, anything beyond the store depth as the depth.
    always_comb begin
        if (r_len_dflt) begin
            eff_len = FW'(MAX_FRAME_LENGTH);
        end else if (r_len == '0) begin
            eff_len = FW'(1);
        end else if (32'(r_len) > 32'(MAX_FRAME_LENGTH)) begin
            eff_len = FW'(MAX_FRAME_LENGTH);
        end else begin
            eff_len = FW'(r_len);
        end
    end

    // Frame weight bookkeeping, taken on element zero only.
    always_comb begin
        acc_base = i_first ? '0 : r_acc;
        sum      = {1'b0, acc_base} + {1'b0, i_weight};
        ovf      = sum - C_ONE_Q16;
        if (frame_start) begin
            n_clears = i_first;
            if (sum >= C_ONE_Q16) begin
                n_fires  = 1'b1;
                n_remain = {1'b0, i_weight} - ovf;
                n_cw     = ovf;
                n_acc    = ovf[C_WEIGHT_W-1:0];
            end else begin
                n_fires  = 1'b0;
                n_remain = '0;
                n_cw     = {1'b0, i_weight};
                n_acc    = sum[C_WEIGHT_W-1:0];
            end
        end else begin
            n_clears = r_clears;
            n_fires  = r_fires;
            n_remain = r_remain;
            n_cw     = r_cw;
            n_acc    = r_acc;
        end
        n_cnt = (e_next >= eff_len) ? '0 : AW'(e_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_len_dflt <= 1'b1;
        end else if (i_cfg_valid) begin
            r_len      <= i_cfg_data;
            r_len_dflt <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_fill   <= '0;
            r_acc    <= '0;
            r_fires  <= 1'b0;
            r_clears <= 1'b1;
            r_remain <= '0;
            r_cw     <= '0;
        end else if (accept) begin
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_fires  <= n_fires;
            r_clears <= n_clears;
            r_remain <= n_remain;
            r_cw     <= n_cw;
            if (e_next > r_fill) begin
                r_fill <= e_next;
            end
        end
    end

    // Only the valid bit is reset; the payload is loaded with each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item.valid <= accept;
        end
        if (accept) begin
            r_item.x       <= i_feature;
            r_item.wa      <= n_fires ? n_remain : n_cw;
            r_item.wb      <= n_cw;
            r_item.fires   <= n_fires;
            r_item.clears  <= n_clears;
            r_item.last    <= (e_ext == eff_len - FW'(1));
            r_item.written <= (e_ext < r_fill);
            r_addr         <= r_cnt;
        end
    end

    assign o_rd_en   = accept;
    assign o_rd_addr = r_cnt;
    assign o_item    = r_item;
    assign o_addr    = r_addr;

endmodule

[sv/ife_mult_cell.sv]
module ife_mult_cell
    import ife_pkg::*;
#(
    parameter int MAX_FRAME_LENGTH = C_MAX_FRAME_LENGTH,
    parameter int AW = (MAX_FRAME_LENGTH > 1) ? $clog2(MAX_FRAME_LENGTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  t_item                       i_item,
    input  logic [AW-1:0]               i_addr,
    input  logic signed [C_STORE_W-1:0] i_rd_data,
    output t_prod                       o_prod,
    output logic [AW-1:0]               o_addr
);

    t_prod                      r_prod;
    logic [AW-1:0]              r_addr;
    logic signed [C_PROD_W-1:0] n_pa;
    logic signed [C_PROD_W-1:0] n_pb;

    // Q4.12 value times an unsigned 17-bit Q0.16 weight.
    assign n_pa = C_PROD_W'(i_item.x) * C_PROD_W'($signed({1'b0, i_item.wa}));
    assign n_pb = C_PROD_W'(i_item.x) * C_PROD_W'($signed({1'b0, i_item.wb}));

    // Only the valid bit is reset; the payload is loaded with each element.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.valid <= 1'b0;
        end else if (i_en) begin
            r_prod.valid <= i_item.valid;
        end
        if (i_en && i_item.valid) begin
            r_prod.pa      <= n_pa;
            r_prod.pb      <= n_pb;
            r_prod.fires   <= i_item.fires;
            r_prod.clears  <= i_item.clears;
            r_prod.last    <= i_item.last;
            r_prod.written <= i_item.written;
            r_prod.rd_data <= i_rd_data;
            r_addr         <= i_addr;
        end
    end

    assign o_prod = r_prod;
    assign o_addr = r_addr;

endmodule

[sv/ife_acc_cell.sv]
module ife_acc_cell
    import ife_pkg::*;
#(
    parameter int MAX_FRAME_LENGTH = C_MAX_FRAME_LENGTH,
    parameter int AW = (MAX_FRAME_LENGTH > 1) ? $clog2(MAX_FRAME_LENGTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  t_prod                       i_prod,
    input  logic [AW-1:0]               i_addr,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output logic signed [C_STORE_W-1:0] o_wr_data,
    output logic                        o_res_valid,
    output logic signed [C_VALUE_W-1:0] o_res_value,
    output logic                        o_res_last
);

    logic                        r_w1_valid;
    logic [AW-1:0]               r_w1_addr;
    logic signed [C_STORE_W-1:0] r_w1_data;
    logic                        r_w2_valid;
    logic [AW-1:0]               r_w2_addr;
    logic signed [C_STORE_W-1:0] r_w2_data;

    logic signed [C_STORE_W-1:0] old;
    logic signed [C_SUM_W-1:0]   sa;
    logic signed [C_SUM_W-1:0]   sb;
    logic signed [C_SUM_W-1:0]   total;
    logic signed [C_SUM_W-1:0]   q;
    logic signed [C_STORE_W-1:0] n_store;

    // The two previous elements may still be missing from the read data, so
    // their write values are forwarded, newest first.
    always_comb begin
        if (i_prod.clears) begin
            old = '0;
        end else if (r_w1_valid && (r_w1_addr == i_addr)) begin
            old = r_w1_data;
        end else if (r_w2_valid && (r_w2_addr == i_addr)) begin
            old = r_w2_data;
        end else if (i_prod.written) begin
            old = i_prod.rd_data;
        end else begin
            old = '0;
        end
        // Arithmetic shifts round toward minus infinity.
        sa    = C_SUM_W'(i_prod.pa >>> 8);
        sb    = C_SUM_W'(i_prod.pb >>> 8);
        total = C_SUM_W'(old) + sa;
        q     = total >>> 8;
        n_store = i_prod.fires ? f_sat24(sb) : f_sat24(total);
    end

    assign o_wr_en     = i_en && i_prod.valid;
    assign o_wr_addr   = i_addr;
    assign o_wr_data   = n_store;
    assign o_res_valid = i_prod.valid && i_prod.fires;
    assign o_res_value = f_sat16(q);
    assign o_res_last  = i_prod.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1_valid <= 1'b0;
            r_w2_valid <= 1'b0;
        end else if (o_wr_en) begin
            r_w1_valid <= 1'b1;
            r_w2_valid <= r_w1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr_en) begin
            r_w1_addr <= i_addr;
            r_w1_data <= n_store;
            r_w2_addr <= r_w1_addr;
            r_w2_data <= r_w1_data;
        end
    end

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ife_pkg::*;

    // One element of a fired embedding, as the block should put it out.
    typedef struct {
        logic signed [C_VALUE_W-1:0] value;
        logic                        last;
    } t_embed_elem;

    // Scoreboard with its own copy of the integrate-and-fire state. Every accepted
    // input item is run through the predictor, and every element of a firing frame
    // is queued. Results leaving the block are compared in order against that queue.
    class embedding_scoreboard;
        logic [C_CFG_W-1:0]          length_reg;
        logic [C_WEIGHT_W-1:0]       acc;
        int unsigned                 elem_idx;
        bit                          fires;
        bit                          clears;
        logic [C_COEF_W-1:0]         remain_wt;
        logic [C_COEF_W-1:0]         frame_wt;
        logic signed [C_STORE_W-1:0] store [C_MAX_FRAME_LENGTH];
        t_embed_elem                 fired_q [$];
        int                          errors;
        int                          checked;
        int                          closings;

        function new();
            length_reg = C_CFG_W'(C_MAX_FRAME_LENGTH);
            acc        = '0;
            elem_idx   = 0;
            fires      = 1'b0;
            clears     = 1'b1;
            remain_wt  = '0;
            frame_wt   = '0;
            foreach (store[i]) store[i] = '0;
            errors     = 0;
            checked    = 0;
            closings   = 0;
        endfunction

        function void set_length(logic [C_CFG_W-1:0] v);
            length_reg = v;
        endfunction

        // A length of zero acts as one; anything above the store depth acts as the depth.
        function int unsigned active_length();
            if (length_reg == 0) return 1;
            if (length_reg > C_MAX_FRAME_LENGTH) return C_MAX_FRAME_LENGTH;
            return length_reg;
        endfunction

        function bit at_frame_start();
            return elem_idx == 0;
        endfunction

        function int pending();
            return fired_q.size();
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Predicts the effect of one accepted item. Shifts of signed values round
        // toward minus infinity, which is what >>> does on a signed longint.
        function void absorb_element(logic [C_WEIGHT_W-1:0] w, logic signed [C_VALUE_W-1:0] x,
                                     bit first);
            int unsigned n;
            int unsigned e;
            int unsigned sum;
            longint      old;
            longint      total;
            t_embed_elem res;

            n = active_length();
            e = elem_idx;
            if (e >= C_MAX_FRAME_LENGTH) e = 0;

            if (e == 0) begin
                clears = first;
                if (first) acc = '0;
                sum = acc + w;
                if (sum >= C_ONE_Q16) begin
                    fires     = 1'b1;
                    frame_wt  = C_COEF_W'(sum - C_ONE_Q16);
                    remain_wt = C_COEF_W'(w) - frame_wt;
                    acc       = frame_wt[C_WEIGHT_W-1:0];
                end else begin
                    fires     = 1'b0;
                    remain_wt = '0;
                    frame_wt  = C_COEF_W'(w);
                    acc       = sum[C_WEIGHT_W-1:0];
                end
            end

            old = clears ? 0 : longint'(store[e]);

            if (fires) begin
                total     = old + ((longint'(x) * longint'(remain_wt)) >>> 8);
                res.value = C_VALUE_W'(clip(total >>> 8, -32768, 32767));
                res.last  = (e == n - 1);
                fired_q.push_back(res);
                store[e] = C_STORE_W'(clip((longint'(x) * longint'(frame_wt)) >>> 8,
                                           -8388608, 8388607));
            end else begin
                total    = old + ((longint'(x) * longint'(frame_wt)) >>> 8);
                store[e] = C_STORE_W'(clip(total, -8388608, 8388607));
            end

            e++;
            elem_idx = (e >= n) ? 0 : e;
        endfunction

        function void check_embedding(logic [C_TDATA_OUT_W-1:0] value, logic last);
            t_embed_elem want;
            checked++;
            if (fired_q.size() == 0) begin
                $error("embedding element with no fired frame pending: value %0d last %0b",
                       $signed(value), last);
                errors++;
                return;
            end
            want = fired_q.pop_front();
            if (value !== want.value) begin
                $error("embedding_value: expected %0d, actual %0d", want.value, $signed(value));
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_embedding: expected %0b, actual %0b", want.last, last);
                errors++;
            end
            if (last === 1'b1) closings++;
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     s_tvalid    = 1'b0;
    logic                     s_tready;
    logic [C_TDATA_IN_W-1:0]  s_tdata     = '0;   // [15:0] weight, [31:16] feature_value
    logic                     s_tuser     = 1'b0; // [0] first_of_sequence
    logic                     m_tvalid;
    logic                     m_tready    = 1'b0;
    logic [C_TDATA_OUT_W-1:0] m_tdata;            // [15:0] embedding_value
    logic                     m_tlast;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [C_CFG_W-1:0]       i_cfg_data  = '0;

    embedding_scoreboard board;

    // Knobs shared between the stimulus and the result sink.
    bit          src_idle_on  = 1'b1;
    bit          snk_idle_on  = 1'b1;
    int unsigned hold_req     = 0;
    int          items_fed    = 0;
    int          lengths_set  = 0;

    integrate_and_fire_embedding_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle stretches are mostly short, less often medium, and
    // now and then long enough to back the pipeline up.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Feature values lean on the saturation corners, zero, minus one and
    // small magnitudes; the rest are uniform over the whole Q4.12 range.
    function automatic logic [C_VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'($urandom_range(0, 127)) - 16'd64;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly short frames so that embeddings fire often. Zero and values past
    // the store depth exercise the clamping of the length register.
    function automatic logic [C_CFG_W-1:0] pick_length();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return C_CFG_W'($urandom_range(C_MAX_FRAME_LENGTH + 1, 1022));
            3, 4:    return C_CFG_W'($urandom_range(9, 40));
            5:       return C_CFG_W'(1);
            default: return C_CFG_W'($urandom_range(2, 8));
        endcase
    endfunction

    // Lowers the input valid unless it is already low, so that a pause right
    // after another pause never schedules a second assignment in one step.
    task automatic stop_source();
        if (s_tvalid) s_tvalid <= 1'b0;
    endtask

    // Offers one item and returns at the clock edge that accepts it. The ready
    // is looked at on the falling edge, where it has settled for the coming
    // rising edge. The valid stays high into the next item unless a gap is drawn.
    task automatic feed(logic [C_WEIGHT_W-1:0] w, logic [C_VALUE_W-1:0] x, bit first);
        s_tvalid <= 1'b1;
        s_tdata  <= {x, w};
        s_tuser  <= first;
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
        board.absorb_element(w, x, first);
        items_fed++;
        if (src_idle_on && $urandom_range(0, 2) == 0) begin
            stop_source();
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // At a frame start the weight is biased toward the middle so that roughly
    // every other frame fires, with zero, full scale and a fresh sequence mixed
    // in. Inside a frame the weight and the sequence flag are ignored by the
    // block, so they carry noise.
    task automatic feed_random();
        logic [C_WEIGHT_W-1:0] w;
        bit                    first;
        if (board.at_frame_start()) begin
            first = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 9))
                0:       w = 16'h0000;
                1:       w = 16'hFFFF;
                2, 3:    w = 16'($urandom);
                default: w = 16'($urandom_range(16384, 49151));
            endcase
        end else begin
            first = 1'($urandom_range(0, 1));
            w     = 16'($urandom);
        end
        feed(w, pick_value(), first);
    endtask

    // The length register is only written once the block has drained. Items
    // of a non-firing frame leave no result behind, so the task also waits out
    // the three-stage pipeline before the write goes out.
    task automatic write_length(logic [C_CFG_W-1:0] v);
        stop_source();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        board.set_length(v);
        lengths_set++;
    endtask

    // Two frames at the full store depth. A length of one first forces the
    // element index back to zero, so both frames are whole. The second frame
    // is certain to fire, which brings out a 512-element embedding.
    task automatic run_long_frames();
        int f;
        int i;
        write_length(C_CFG_W'(1));
        feed_random();
        write_length('1);
        for (f = 0; f < 2; f++) begin
            for (i = 0; i < C_MAX_FRAME_LENGTH; i++) begin
                if (i == 0) begin
                    feed(16'($urandom_range(60000, 65535)), pick_value(), f == 0);
                end else begin
                    feed(16'($urandom), pick_value(), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // Result sink. The ready for each cycle is chosen on the rising edge; a
    // hold-off requested by the stimulus is counted down here, cycle by cycle,
    // while the sender keeps offering items.
    initial begin : result_sink
        int unsigned              stall_left;
        bit                       take;
        logic [C_TDATA_OUT_W-1:0] got_value;
        logic                     got_last;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            take      = m_tvalid && m_tready;
            got_value = m_tdata;
            got_last  = m_tlast;
            @(posedge i_clk);
            if (take) board.check_embedding(got_value, got_last);
            if (hold_req != 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end else if (stall_left == 0 && snk_idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int ph;
        int n;

        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A few items at the reset length of 512 leave the element index at three.
        // Shrinking the length to two then makes the next item run at an index
        // past the new end: it must not close an embedding, and the index wraps.
        feed(16'd1000, 16'h1234, 1'b1);
        feed(16'hFFFF, 16'h8000, 1'b0);
        feed(16'h0000, 16'h7FFF, 1'b1);
        write_length(C_CFG_W'(2));
        feed(16'hFFFF, 16'h7FFF, 1'b0);

        // Positive saturation. A new sequence with full weight fills both store
        // entries near the top without firing. A one-element frame then fires on
        // entry zero alone, so that entry is reset while entry one is not. Back
        // at length two, another full-weight frame pushes entry one past the
        // store range, and the firing frame after it overflows the output.
        feed(16'hFFFF, 16'h7FFF, 1'b1);
        feed(16'hFFFF, 16'h7FFF, 1'b0);
        write_length(C_CFG_W'(1));
        feed(16'h0001, 16'h7FFF, 1'b0);
        write_length(C_CFG_W'(2));
        feed(16'hFFFF, 16'h7FFF, 1'b0);
        feed(16'h0000, 16'h7FFF, 1'b1);
        feed(16'h0001, 16'h7FFF, 1'b0);
        feed(16'h0000, 16'h7FFF, 1'b1);

        // The same walk with the most negative value.
        feed(16'hFFFF, 16'h8000, 1'b1);
        feed(16'hFFFF, 16'h8000, 1'b0);
        write_length(C_CFG_W'(1));
        feed(16'h0001, 16'h8000, 1'b0);
        write_length(C_CFG_W'(2));
        feed(16'hFFFF, 16'h8000, 1'b0);
        feed(16'hFFFF, 16'h8000, 1'b0);
        feed(16'h0001, 16'h8000, 1'b0);
        feed(16'hFFFF, 16'h8000, 1'b1);

        // A length of zero acts as one: every element is a frame of its own.
        write_length('0);
        feed(16'hFFFF, 16'hFFFF, 1'b1);
        feed(16'h0001, 16'h0001, 1'b0);

        // Random phases, each at a fresh length, until about 1200 items have
        // gone in. A write often lands mid-frame, which is part of what is being
        // checked. Phase one holds the sink off for a long stretch with the
        // source running flat out, and phase three runs two frames at the full
        // depth.
        for (ph = 0; items_fed < 1200; ph++) begin
            if (ph == 3) begin
                run_long_frames();
                continue;
            end
            if (ph == 1) begin
                write_length(C_CFG_W'(4));
                src_idle_on = 1'b0;
                snk_idle_on = 1'b1;
                hold_req    = 300;
                n           = 100;
            end else begin
                write_length(pick_length());
                src_idle_on = ($urandom_range(0, 3) != 0);
                snk_idle_on = ($urandom_range(0, 3) != 0);
                n           = $urandom_range(8, 120);
            end
            repeat (n) feed_random();
        end

        stop_source();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Fed %0d elements under %0d frame-length writes, down to zero and up to",
                 items_fed, lengths_set);
        $display("the full depth; %0d embedding elements checked, %0d of them closing one.",
                 board.checked, board.closings);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin : watchdog
        #15ms;
        $error("run did not finish in time; %0d fired elements never arrived",
               board.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
sv/ife_pkg.sv
sv/ife_store.sv
sv/ife_frame.sv
sv/ife_mult_cell.sv
sv/ife_acc_cell.sv
sv/integrate_and_fire_embedding_unit.sv
tb/tb.sv
